@@ hdl/iqc_pkg.sv @@
// iqc_pkg: types, constants and saturation helpers for the iq imbalance corrector
// used by iqc_mul, iqc_dsu and iq_imbalance_corrector; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iqc_pkg;

   localparam int BLOCK_MAX = 65536;
   localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DSU_W     = 64;
   localparam int STEP_W    = $clog2(DSU_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DC_ALPHA    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_ALPHA = 1'b1;

   localparam logic [31:0] ALPHA_RESET = 32'd42950;
   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
   localparam logic [DSU_W-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic sqrt_op;
   } dsu_ctl_type;

   typedef struct packed {
      logic             done;
      logic [DSU_W-1:0] value;
   } dsu_res_type;

   function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
      logic signed [15:0] r;
      if (v > 38'sd32767) r = 16'sh7fff;
      else if (v < -38'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) r = 32'sh7fff_ffff;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/iqc_mul.sv @@
// iqc_mul: shared signed multiplier with registered product
// depends on iqc_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module iqc_mul
   import iqc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  mul_a,
   input  wire logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]      prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

`default_nettype wire

@@ hdl/iqc_dsu.sv @@
// iqc_dsu: bit-serial unsigned divider and integer square root, one step a cycle
// depends on iqc_pkg for the control and result structs
`timescale 1ns / 1ps
`default_nettype none

module iqc_dsu
   import iqc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dsu_ctl_type      ctl,
   input  wire logic [DSU_W-1:0] opa,
   input  wire logic [DSU_W-1:0] opb,
   output dsu_res_type           res
);

   logic              busy_ff;
   logic              done_ff;
   logic              sqrt_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DSU_W:0]    rem_ff;
   logic [DSU_W-1:0]  quo_ff;
   logic [DSU_W-1:0]  div_ff;

   logic [DSU_W:0]    rem_sh;
   logic [DSU_W-1:0]  root_try;
   logic              ge;
   logic [DSU_W:0]    rem_in;
   logic [DSU_W-1:0]  quo_in;
   logic [DSU_W-1:0]  div_in;

   always_comb begin
      rem_sh   = {rem_ff[DSU_W-1:0], quo_ff[DSU_W-1]};
      root_try = quo_ff + div_ff;
      if (sqrt_ff) begin
         // quo holds the partial root, div holds the current bit pair
         ge     = rem_ff[DSU_W-1:0] >= root_try;
         rem_in = ge ? {1'b0, rem_ff[DSU_W-1:0] - root_try} : rem_ff;
         quo_in = ge ? (quo_ff >> 1) + div_ff : quo_ff >> 1;
         div_in = div_ff >> 2;
      end else begin
         ge     = rem_sh >= {1'b0, div_ff};
         rem_in = ge ? rem_sh - {1'b0, div_ff} : rem_sh;
         quo_in = {quo_ff[DSU_W-2:0], ge};
         div_in = div_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            sqrt_ff <= ctl.sqrt_op;
            if (ctl.sqrt_op) begin
               step_ff <= STEP_W'(DSU_W / 2 - 1);
               rem_ff  <= {1'b0, opa};
               quo_ff  <= '0;
               div_ff  <= DSU_W'(1) << (DSU_W - 2);
            end else begin
               step_ff <= STEP_W'(DSU_W - 1);
               rem_ff  <= '0;
               quo_ff  <= opa;
               div_ff  <= opb;
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            div_ff <= div_in;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
      end
   end

   assign res.done  = done_ff;
   assign res.value = quo_ff;

endmodule

`default_nettype wire

@@ hdl/iq_imbalance_corrector.sv @@
// iq_imbalance_corrector: sequencer, estimate and coefficient state, output register
// depends on iqc_pkg, iqc_mul and iqc_dsu
//
// usage: samples enter on the req_ channel (valid/stall), one corrected beat
// leaves on the rsp_ channel for every input beat, in order. the beat with
// last set (or the BLOCK_MAX-th beat of a block) closes the block and starts
// the estimate and coefficient update for the next block.
// each sample runs through one shared 34x34 multiplier in seven issues,
// and req_stall stays high until its result is in the output register.
// a block end adds the update: up to six 64-step divisions and three
// 32-step square roots in the shared divide/sqrt unit plus normalizing
// shifts; req_stall is high throughout.
// a stalled result stays in the output register; the sequencer waits
// only when it has a new result and the register is still full.
// reset (synchronous) restores the estimates and coefficients to their
// neutral values, both alpha registers to 42950 and clears the sums.
// csr_ writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module iq_imbalance_corrector
   import iqc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_write_data
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_M1    = 5'd1;
   localparam logic [4:0] S_M2    = 5'd2;
   localparam logic [4:0] S_M3    = 5'd3;
   localparam logic [4:0] S_M4    = 5'd4;
   localparam logic [4:0] S_M5    = 5'd5;
   localparam logic [4:0] S_M6    = 5'd6;
   localparam logic [4:0] S_M7    = 5'd7;
   localparam logic [4:0] S_M8    = 5'd8;
   localparam logic [4:0] S_OUT   = 5'd9;
   localparam logic [4:0] B_KD    = 5'd10;
   localparam logic [4:0] B_KP    = 5'd11;
   localparam logic [4:0] B_KP2   = 5'd12;
   localparam logic [4:0] B_PREP  = 5'd13;
   localparam logic [4:0] B_NORM  = 5'd14;
   localparam logic [4:0] B_DGO   = 5'd15;
   localparam logic [4:0] B_DWAIT = 5'd16;
   localparam logic [4:0] B_TMUL  = 5'd17;
   localparam logic [4:0] B_TADD  = 5'd18;
   localparam logic [4:0] C_GQ    = 5'd19;
   localparam logic [4:0] C_GQW   = 5'd20;
   localparam logic [4:0] C_INV   = 5'd21;
   localparam logic [4:0] C_INVW  = 5'd22;
   localparam logic [4:0] C_GI    = 5'd23;
   localparam logic [4:0] C_GIW   = 5'd24;
   localparam logic [4:0] C_S2    = 5'd25;
   localparam logic [4:0] C_C2    = 5'd26;
   localparam logic [4:0] C_RTW   = 5'd27;
   localparam logic [4:0] C_SECW  = 5'd28;
   localparam logic [4:0] C_TAN   = 5'd29;
   localparam logic [4:0] C_TAN2  = 5'd30;
   localparam logic [4:0] C_END   = 5'd31;

   localparam logic [1:0] SEL_DC_I  = 2'd0;
   localparam logic [1:0] SEL_DC_Q  = 2'd1;
   localparam logic [1:0] SEL_RATIO = 2'd2;
   localparam logic [1:0] SEL_SINE  = 2'd3;

   logic [4:0]              state_ff;
   logic [31:0]             dc_alpha_ff;
   logic [31:0]             power_alpha_ff;
   logic signed [31:0]      dc_est_i_ff;
   logic signed [31:0]      dc_est_q_ff;
   logic signed [31:0]      ratio_ff;
   logic signed [31:0]      sine_ff;
   logic signed [31:0]      gain_i_ff;
   logic signed [31:0]      gain_q_ff;
   logic signed [31:0]      sec_ff;
   logic signed [31:0]      tan_ff;
   logic signed [47:0]      raw_i_ff;
   logic signed [47:0]      raw_q_ff;
   logic [63:0]             ssi_ff;
   logic [63:0]             ssq_ff;
   logic signed [63:0]      cross_ff;
   logic [CNT_W-1:0]        cnt_ff;

   logic signed [MUL_W-1:0] di_ff;
   logic signed [MUL_W-1:0] dq_ff;
   logic signed [22:0]      gi_ff;
   logic signed [22:0]      gq_ff;
   logic signed [PROD_W-1:0] tg_ff;
   logic signed [37:0]      qo_ff;
   logic                    last_ff;

   logic [30:0]             kd_ff;
   logic [30:0]             kp_ff;
   logic [1:0]              sel_ff;
   logic [63:0]             m_ff;
   logic [63:0]             den_ff;
   logic                    neg_ff;
   logic signed [MUL_W-1:0] target_ff;
   logic [32:0]             inv_ff;

   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;

   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   dsu_ctl_type              dsu_ctl;
   logic [DSU_W-1:0]         dsu_a;
   logic [DSU_W-1:0]         dsu_b;
   dsu_res_type              dsu_res;

   logic                     accept;
   logic signed [31:0]       est_sel;
   logic [30:0]              k_sel;
   logic signed [47:0]       raw_sel;
   logic [47:0]              raw_mag;
   logic signed [63:0]       cross2;
   logic [63:0]              cross_mag;
   logic [48:0]              k_prod;
   logic [30:0]              k_clamp;
   logic [31:0]              q_sat;
   logic signed [MUL_W-1:0]  q_signed;
   logic signed [32:0]       rsum;
   logic [30:0]              vq;
   logic [33:0]              vsum;
   logic [32:0]              vhalf;
   logic [30:0]              vi;
   logic signed [63:0]       c2_diff;
   logic signed [33:0]       c2;
   logic                     c2_pos;
   logic                     ratio_pos;
   logic signed [37:0]       p_shift;
   logic signed [39:0]       est_sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      case (sel_ff)
         SEL_DC_I:  est_sel = dc_est_i_ff;
         SEL_DC_Q:  est_sel = dc_est_q_ff;
         SEL_RATIO: est_sel = ratio_ff;
         default:   est_sel = sine_ff;
      endcase
      k_sel     = sel_ff[1] ? kp_ff : kd_ff;
      raw_sel   = (sel_ff == SEL_DC_I) ? raw_i_ff : raw_q_ff;
      raw_mag   = raw_sel[47] ? 48'(-raw_sel) : 48'(raw_sel);
      cross2    = {cross_ff[62:0], 1'b0};
      cross_mag = cross2[63] ? 64'(-cross2) : 64'(cross2);
      k_prod    = prod_ff[50:2];
      k_clamp   = (k_prod > 49'(ONE_Q30)) ? 31'(ONE_Q30) : k_prod[30:0];
      q_sat     = (dsu_res.value > 64'(INT32_MAX)) ? 32'(INT32_MAX) : dsu_res.value[31:0];
      q_signed  = neg_ff ? -MUL_W'(q_sat) : MUL_W'(q_sat);
      rsum      = {ratio_ff[31], ratio_ff} + 33'(ONE_Q30);
      vq        = rsum[32] ? '0 : rsum[31:1];
      vsum      = 34'(ONE_Q30) + {1'b0, inv_ff};
      vhalf     = vsum[33:1];
      vi        = (vhalf > 33'(INT32_MAX)) ? 31'(INT32_MAX) : vhalf[30:0];
      c2_diff   = $signed(ONE_Q60) - prod_ff[63:0];
      c2        = c2_diff[63:30];
      c2_pos    = !c2[33] && (c2 != '0);
      ratio_pos = !ratio_ff[31] && (ratio_ff != '0);
      p_shift   = prod_ff[PROD_W-1:30];
      est_sum   = {{2{p_shift[37]}}, p_shift} + {{8{est_sel[31]}}, est_sel};
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_M1: begin
            mul_a = MUL_W'($signed(di_ff[MUL_W-1:15]));
            mul_b = MUL_W'($signed(di_ff[MUL_W-1:15]));
         end
         S_M2: begin
            mul_a = MUL_W'($signed(dq_ff[MUL_W-1:15]));
            mul_b = MUL_W'($signed(dq_ff[MUL_W-1:15]));
         end
         S_M3: begin
            mul_a = di_ff;
            mul_b = MUL_W'(gain_i_ff);
         end
         S_M4: begin
            mul_a = dq_ff;
            mul_b = MUL_W'(gain_q_ff);
         end
         S_M5: begin
            mul_a = MUL_W'(tan_ff);
            mul_b = MUL_W'(gi_ff);
         end
         S_M6: begin
            mul_a = MUL_W'(sec_ff);
            mul_b = MUL_W'(gq_ff);
         end
         S_M7: begin
            mul_a = MUL_W'(gi_ff);
            mul_b = MUL_W'(gq_ff);
         end
         B_KD: begin
            mul_a = {2'b00, dc_alpha_ff};
            mul_b = MUL_W'(cnt_ff);
         end
         B_KP: begin
            mul_a = {2'b00, power_alpha_ff};
            mul_b = MUL_W'(cnt_ff);
         end
         B_TMUL: begin
            mul_a = target_ff - MUL_W'(est_sel);
            mul_b = MUL_W'(k_sel);
         end
         C_S2: begin
            mul_a = MUL_W'(sine_ff);
            mul_b = MUL_W'(sine_ff);
         end
         C_TAN: begin
            mul_a = MUL_W'(sine_ff);
            mul_b = MUL_W'(sec_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // operand select and start for the divide/sqrt unit
   always_comb begin
      dsu_ctl.start   = 1'b0;
      dsu_ctl.sqrt_op = 1'b0;
      dsu_a           = ONE_Q60;
      dsu_b           = '0;
      unique case (state_ff)
         B_DGO: begin
            dsu_ctl.start = 1'b1;
            dsu_a         = m_ff;
            dsu_b         = den_ff;
         end
         C_GQ: begin
            dsu_ctl.start   = 1'b1;
            dsu_ctl.sqrt_op = 1'b1;
            dsu_a           = {3'b000, vq, 30'd0};
         end
         C_INV: begin
            dsu_ctl.start = ratio_pos;
            dsu_b         = {32'd0, ratio_ff};
         end
         C_GI: begin
            dsu_ctl.start   = 1'b1;
            dsu_ctl.sqrt_op = 1'b1;
            dsu_a           = {3'b000, vi, 30'd0};
         end
         C_C2: begin
            dsu_ctl.start   = c2_pos;
            dsu_ctl.sqrt_op = 1'b1;
            dsu_a           = {c2, 30'd0};
         end
         C_RTW: begin
            // the root goes straight back in as the secant divisor
            dsu_ctl.start = dsu_res.done;
            dsu_b         = dsu_res.value;
         end
         default: begin
            dsu_ctl.start = 1'b0;
         end
      endcase
   end

   iqc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   iqc_dsu u_dsu (
      .clock (clock),
      .reset (reset),
      .ctl   (dsu_ctl),
      .opa   (dsu_a),
      .opb   (dsu_b),
      .res   (dsu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         dc_alpha_ff    <= ALPHA_RESET;
         power_alpha_ff <= ALPHA_RESET;
         dc_est_i_ff    <= '0;
         dc_est_q_ff    <= '0;
         ratio_ff       <= ONE_Q30;
         sine_ff        <= '0;
         gain_i_ff      <= ONE_Q30;
         gain_q_ff      <= ONE_Q30;
         sec_ff         <= ONE_Q30;
         tan_ff         <= '0;
         raw_i_ff       <= '0;
         raw_q_ff       <= '0;
         ssi_ff         <= '0;
         ssq_ff         <= '0;
         cross_ff       <= '0;
         cnt_ff         <= '0;
         sel_ff         <= SEL_DC_I;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DC_ALPHA:    dc_alpha_ff    <= csr_write_data;
               CSR_POWER_ALPHA: power_alpha_ff <= csr_write_data;
               default:         dc_alpha_ff    <= dc_alpha_ff;
            endcase
         end

         // in S_OUT the output register is reloaded below instead
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  di_ff <= $signed({{3{req_payload.sample_i[15]}}, req_payload.sample_i,
                                    15'd0}) - MUL_W'(dc_est_i_ff);
                  dq_ff <= $signed({{3{req_payload.sample_q[15]}}, req_payload.sample_q,
                                    15'd0}) - MUL_W'(dc_est_q_ff);
                  raw_i_ff <= raw_i_ff + 48'(req_payload.sample_i);
                  raw_q_ff <= raw_q_ff + 48'(req_payload.sample_q);
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  last_ff  <= req_payload.last;
                  state_ff <= S_M1;
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: begin
               ssi_ff   <= ssi_ff + prod_ff[63:0];
               state_ff <= S_M3;
            end
            S_M3: begin
               ssq_ff   <= ssq_ff + prod_ff[63:0];
               state_ff <= S_M4;
            end
            S_M4: begin
               gi_ff    <= prod_ff[PROD_W-1:45];
               state_ff <= S_M5;
            end
            S_M5: begin
               gq_ff    <= prod_ff[PROD_W-1:45];
               state_ff <= S_M6;
            end
            S_M6: begin
               tg_ff    <= prod_ff;
               state_ff <= S_M7;
            end
            S_M7: begin
               qo_ff    <= 38'((prod_ff - tg_ff) >>> 30);
               state_ff <= S_M8;
            end
            S_M8: begin
               cross_ff <= cross_ff + prod_ff[63:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_payload_ff.out_i <= sat16(38'(gi_ff));
                  rsp_payload_ff.out_q <= sat16(qo_ff);
                  if (last_ff || (cnt_ff >= CNT_W'(BLOCK_MAX))) begin
                     state_ff <= B_KD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            B_KD: state_ff <= B_KP;
            B_KP: begin
               kd_ff    <= k_clamp;
               state_ff <= B_KP2;
            end
            B_KP2: begin
               kp_ff    <= k_clamp;
               sel_ff   <= SEL_DC_I;
               state_ff <= B_PREP;
            end
            B_PREP: begin
               case (sel_ff)
                  SEL_DC_I, SEL_DC_Q: begin
                     neg_ff   <= raw_sel[47];
                     m_ff     <= {16'd0, raw_mag} << 15;
                     den_ff   <= 64'(cnt_ff);
                     state_ff <= B_DGO;
                  end
                  SEL_RATIO: begin
                     if (ssq_ff == '0) begin
                        sel_ff <= SEL_SINE;
                     end else begin
                        neg_ff   <= 1'b0;
                        m_ff     <= ssi_ff;
                        den_ff   <= ssq_ff;
                        state_ff <= B_NORM;
                     end
                  end
                  default: begin
                     if ((ssi_ff + ssq_ff) == '0) begin
                        state_ff <= C_GQ;
                     end else begin
                        neg_ff   <= cross2[63];
                        m_ff     <= cross_mag;
                        den_ff   <= ssi_ff + ssq_ff;
                        state_ff <= B_NORM;
                     end
                  end
               endcase
            end
            B_NORM: begin
               // halve both until the numerator fits in 32 bits
               if (m_ff[63:32] != '0) begin
                  m_ff   <= m_ff >> 1;
                  den_ff <= den_ff >> 1;
               end else if (den_ff == '0) begin
                  target_ff <= neg_ff ? -MUL_W'(INT32_MAX) : MUL_W'(INT32_MAX);
                  state_ff  <= B_TMUL;
               end else begin
                  m_ff     <= m_ff << 30;
                  state_ff <= B_DGO;
               end
            end
            B_DGO: state_ff <= B_DWAIT;
            B_DWAIT: begin
               if (dsu_res.done) begin
                  target_ff <= q_signed;
                  state_ff  <= B_TMUL;
               end
            end
            B_TMUL: state_ff <= B_TADD;
            B_TADD: begin
               case (sel_ff)
                  SEL_DC_I:  dc_est_i_ff <= sat32(est_sum);
                  SEL_DC_Q:  dc_est_q_ff <= sat32(est_sum);
                  SEL_RATIO: ratio_ff    <= sat32(est_sum);
                  default:   sine_ff     <= sat32(est_sum);
               endcase
               if (sel_ff == SEL_SINE) begin
                  state_ff <= C_GQ;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= B_PREP;
               end
            end
            C_GQ: state_ff <= C_GQW;
            C_GQW: begin
               if (dsu_res.done) begin
                  gain_q_ff <= $signed(q_sat);
                  state_ff  <= C_INV;
               end
            end
            C_INV: begin
               if (ratio_pos) begin
                  state_ff <= C_INVW;
               end else begin
                  inv_ff   <= 33'h1_0000_0000;
                  state_ff <= C_GI;
               end
            end
            C_INVW: begin
               if (dsu_res.done) begin
                  inv_ff   <= (dsu_res.value > 64'h1_0000_0000) ? 33'h1_0000_0000
                                                               : dsu_res.value[32:0];
                  state_ff <= C_GI;
               end
            end
            C_GI: state_ff <= C_GIW;
            C_GIW: begin
               if (dsu_res.done) begin
                  gain_i_ff <= $signed(q_sat);
                  state_ff  <= C_S2;
               end
            end
            C_S2: state_ff <= C_C2;
            C_C2: begin
               if (c2_pos) begin
                  state_ff <= C_RTW;
               end else begin
                  // sine at or beyond unity
                  sec_ff <= INT32_MAX;
                  if (!sine_ff[31] && (sine_ff != '0)) tan_ff <= INT32_MAX;
                  else if (sine_ff[31]) tan_ff <= -INT32_MAX;
                  else tan_ff <= '0;
                  state_ff <= C_END;
               end
            end
            C_RTW: begin
               if (dsu_res.done) begin
                  state_ff <= C_SECW;
               end
            end
            C_SECW: begin
               if (dsu_res.done) begin
                  sec_ff   <= $signed(q_sat);
                  state_ff <= C_TAN;
               end
            end
            C_TAN: state_ff <= C_TAN2;
            C_TAN2: begin
               tan_ff   <= sat32(40'(p_shift));
               state_ff <= C_END;
            end
            C_END: begin
               raw_i_ff <= '0;
               raw_q_ff <= '0;
               ssi_ff   <= '0;
               ssq_ff   <= '0;
               cross_ff <= '0;
               cnt_ff   <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ dv/iq_imbalance_corrector_tb.sv @@
// iq_imbalance_corrector_tb: self-checking bench for the iq imbalance corrector
// queue-fed driver, checking monitor and a bit-exact corrector model; needs iqc_pkg
`timescale 1ns / 1ps

module iq_imbalance_corrector_tb;
   import iqc_pkg::*;

   localparam int  SETTLE_CYCLES = 800;
   localparam int  CYCLE_LIMIT   = 4000000;
   localparam int  HOLD_AFTER    = 100;
   localparam int  HOLD_CYCLES   = 400;
   localparam longint Q30        = 64'sd1 << 30;
   localparam longint Q60        = 64'sd1 << 60;
   localparam longint I32MAX     = 64'sd2147483647;

   typedef struct {
      req_payload_type beat;
   } pending_beat_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DC_ALPHA;
   logic [31:0]     csr_write_data = '0;

   pending_beat_type pending_beats[$];
   rsp_payload_type  expected_samples[$];
   int               mismatches = 0;
   int               results_seen = 0;
   int               cycles = 0;
   bit               steady_mode = 1'b0;

   // corrector model state
   logic [31:0]        dc_rate, power_rate;
   logic signed [31:0] offset_i, offset_q, ratio_est, sine_est;
   logic signed [31:0] gain_i, gain_q, sec_c, tan_c;
   longint             acc_i, acc_q, corr_acc;
   longint unsigned    pow_i, pow_q;
   longint unsigned    sample_count;

   iq_imbalance_corrector u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clip32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fff_ffff;
      if (v < -128'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] clip16(logic signed [127:0] v);
      if (v > 128'sd32767) return 16'sh7fff;
      if (v < -128'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // quotient in Q.30 with magnitude saturation
   function automatic longint ratio_q30(longint num, longint unsigned den);
      bit neg;
      longint unsigned m, q;
      neg = num < 0;
      m = neg ? 64'd0 - num : num;
      while (m >= (64'd1 << 32)) begin
         m = m >> 1;
         den = den >> 1;
      end
      if (den == 0) q = I32MAX;
      else q = (m << 30) / den;
      if (q > I32MAX) q = I32MAX;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [31:0] step_toward(logic signed [31:0] est, longint target,
                                                      longint unsigned k);
      logic signed [127:0] diff, kk, est_w;
      diff = target - longint'(est);
      kk = $signed({64'd0, k});
      est_w = est;
      return clip32(est_w + ((diff * kk) >>> 30));
   endfunction

   task automatic refresh_coefs();
      longint r, s, v, inv, c2;
      longint unsigned root, sc;
      logic signed [127:0] sw;
      r = ratio_est;
      s = sine_est;
      v = Q30 + r;
      if (v < 0) v = 0;
      v = v >>> 1;
      gain_q = clip32($signed({64'd0, int_sqrt(longint'(v) << 30)}));
      if (r <= 0) inv = 64'sd1 << 32;
      else begin
         inv = Q60 / r;
         if (inv > (64'sd1 << 32)) inv = 64'sd1 << 32;
      end
      v = (Q30 + inv) >>> 1;
      if (v > I32MAX) v = I32MAX;
      gain_i = clip32($signed({64'd0, int_sqrt(longint'(v) << 30)}));
      c2 = (Q60 - s * s) >>> 30;
      if (c2 <= 0) begin
         sec_c = 32'sh7fff_ffff;
         tan_c = s > 0 ? 32'sh7fff_ffff : (s < 0 ? -32'sh7fff_ffff : 32'sh0);
      end else begin
         root = int_sqrt(longint'(c2) << 30);
         sc = 64'd1 << 60;
         sc = sc / root;
         sec_c = clip32($signed({64'd0, sc}));
         sw = s * longint'(sec_c);
         tan_c = clip32(sw >>> 30);
      end
   endtask

   task automatic close_block();
      longint unsigned kd, kp, den;
      longint cnt;
      cnt = sample_count;
      kd = (64'(dc_rate) * sample_count) >> 2;
      kp = (64'(power_rate) * sample_count) >> 2;
      if (kd > Q30) kd = Q30;
      if (kp > Q30) kp = Q30;
      offset_i = step_toward(offset_i, (acc_i * 32768) / cnt, kd);
      offset_q = step_toward(offset_q, (acc_q * 32768) / cnt, kd);
      if (pow_q != 0) ratio_est = step_toward(ratio_est, ratio_q30(longint'(pow_i), pow_q), kp);
      den = pow_i + pow_q;
      if (den != 0) sine_est = step_toward(sine_est, ratio_q30(2 * corr_acc, den), kp);
      refresh_coefs();
      acc_i = 0; acc_q = 0; corr_acc = 0; pow_i = 0; pow_q = 0; sample_count = 0;
   endtask

   task automatic model_reset();
      dc_rate = ALPHA_RESET; power_rate = ALPHA_RESET;
      offset_i = 0; offset_q = 0; sine_est = 0; tan_c = 0;
      ratio_est = ONE_Q30; gain_i = ONE_Q30; gain_q = ONE_Q30; sec_c = ONE_Q30;
      acc_i = 0; acc_q = 0; corr_acc = 0; pow_i = 0; pow_q = 0; sample_count = 0;
   endtask

   task automatic correct_sample(req_payload_type p);
      longint x, y, di, dq, si, sq;
      logic signed [127:0] wdi, wdq, wgi, wgq, wqo;
      rsp_payload_type o;
      x = p.sample_i;
      y = p.sample_q;
      di = x * 32768 - longint'(offset_i);
      dq = y * 32768 - longint'(offset_q);
      si = di >>> 15;
      sq = dq >>> 15;
      wdi = di;
      wdq = dq;
      wgi = (wdi * gain_i) >>> 45;
      wgq = (wdq * gain_q) >>> 45;
      wqo = (wgq * sec_c - wgi * tan_c) >>> 30;
      acc_i += x;
      acc_q += y;
      pow_i += longint'(si * si);
      pow_q += longint'(sq * sq);
      corr_acc += longint'(wgi[63:0]) * longint'(wgq[63:0]);
      o.out_i = clip16(wgi);
      o.out_q = clip16(wqo);
      expected_samples.push_back(o);
      sample_count++;
      if (p.last || sample_count >= BLOCK_MAX) close_block();
   endtask

   function automatic int pick_gap();
      int r;
      if (steady_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // driver: the beat at the head of pending_beats is on the bus until accepted
   int gap_left = 0;
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            correct_sample(req_payload);
            void'(pending_beats.pop_front());
            next_valid = 1'b0;
            gap_left = pick_gap();
         end
         if (!next_valid) begin
            if (gap_left > 0) gap_left--;
            else if (pending_beats.size() > 0) begin
               next_valid = 1'b1;
               req_payload <= pending_beats[0].beat;
            end
         end
         req_valid <= next_valid;
      end
   end

   // monitor with random stalls and one long hold-off
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_payload_type want;
      logic next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %0d/%0d",
                                         rsp_payload.out_i, rsp_payload.out_q));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.out_i !== want.out_i)
                  report_mismatch($sformatf("out_i %0d, expected %0d",
                                            rsp_payload.out_i, want.out_i));
               if (rsp_payload.out_q !== want.out_q)
                  report_mismatch($sformatf("out_q %0d, expected %0d",
                                            rsp_payload.out_q, want.out_q));
            end
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (!steady_mode && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("iq_imbalance_corrector verification failed");
         $finish;
      end
   end

   task automatic queue_sample(int si, int sq, bit last);
      pending_beat_type b;
      b.beat.sample_i = si[15:0];
      b.beat.sample_q = sq[15:0];
      b.beat.last = last;
      pending_beats.push_back(b);
   endtask

   // sender pause: everything out, then let a block update finish
   task automatic drain();
      while (pending_beats.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_index <= idx;
      csr_write_data <= data;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DC_ALPHA) dc_rate = data;
      else power_rate = data;
      @(posedge clock);
   endtask

   task automatic queue_random_blocks(int beats);
      int n, len, kind, a, b, off_i, off_q;
      n = 0;
      while (n < beats) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) len = $urandom_range(2, 12);
         else if (kind < 8) len = $urandom_range(13, 64);
         else len = 1;
         off_i = $urandom_range(0, 8000) - 4000;
         off_q = $urandom_range(0, 8000) - 4000;
         kind = $urandom_range(0, 2);
         for (int k = 0; k < len; k++) begin
            if (kind == 0) begin
               a = $urandom_range(0, 65535) - 32768;
               b = $urandom_range(0, 65535) - 32768;
            end else if (kind == 1) begin
               a = off_i + $urandom_range(0, 20000) - 10000;
               b = off_q + $urandom_range(0, 20000) - 10000;
            end else begin
               // correlated pair, like a skewed quadrature path
               a = $urandom_range(0, 40000) - 20000;
               b = (a * 3) / 4 + off_q / 4 + $urandom_range(0, 2000) - 1000;
            end
            queue_sample(a, b, k == len - 1);
         end
         n += len;
      end
   endtask

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero block: both denominators zero
      for (int k = 0; k < 4; k++) queue_sample(0, 0, k == 3);
      queue_sample(32767, 32767, 1'b0);
      queue_sample(-32768, -32768, 1'b0);
      queue_sample(32767, -32768, 1'b0);
      queue_sample(-32768, 32767, 1'b1);
      queue_sample(12345, -321, 1'b1);
      drain();

      write_reg(CSR_DC_ALPHA, 32'hffff_ffff);
      write_reg(CSR_POWER_ALPHA, 32'hffff_ffff);
      // equal i and q: sin(phi) driven to one
      for (int k = 0; k < 4; k++)
         queue_sample(k[0] ? 30000 : -30000, k[0] ? 30000 : -30000, k == 3);
      // opposite i and q: sin(phi) toward minus one
      for (int k = 0; k < 4; k++)
         queue_sample(k[0] ? 30000 : -30000, k[0] ? -30000 : 30000, k == 3);
      // no in-phase power: ratio collapses to zero
      for (int k = 0; k < 4; k++) queue_sample(0, k[0] ? 1000 : -1000, k == 3);
      queue_sample(5000, 7000, 1'b1);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_reg(CSR_DC_ALPHA, ALPHA_RESET);
                     write_reg(CSR_POWER_ALPHA, ALPHA_RESET); end
            1: begin write_reg(CSR_DC_ALPHA, 32'd0);
                     write_reg(CSR_POWER_ALPHA, 32'hffff_ffff); end
            2: begin write_reg(CSR_DC_ALPHA, $urandom);
                     write_reg(CSR_POWER_ALPHA, $urandom_range(0, 1 << 24)); end
            3: begin write_reg(CSR_DC_ALPHA, 32'hffff_ffff);
                     write_reg(CSR_POWER_ALPHA, 32'd0); end
            default: begin write_reg(CSR_DC_ALPHA, $urandom_range(1 << 20, 1 << 28));
                           write_reg(CSR_POWER_ALPHA, $urandom); end
         endcase
         steady_mode = (ph == 2);
         queue_random_blocks(150);
         drain();
      end

      if (mismatches == 0) $display("iq_imbalance_corrector verification clean");
      else $display("iq_imbalance_corrector verification failed");
      $finish;
   end

endmodule
